// ----- hdl/tdrc_pkg.sv -----
// ----------------------------------------------------------------------------
// TFTP data receive checker package
// Shared constants for the TFTP read-transfer header checker.
// ----------------------------------------------------------------------------
package tdrc_pkg;

	// Default data segment size of one TFTP block in bytes.
	localparam int unsigned SEGMENT_BYTES_DEFAULT = 512;

	// Field widths.
	localparam int unsigned LEN_W     = 11;
	localparam int unsigned PORT_W    = 16;
	localparam int unsigned ADDR_W    = 32;
	localparam int unsigned OPCODE_W  = 16;
	localparam int unsigned BLOCK_W   = 16;
	localparam int unsigned VERDICT_W = 4;
	localparam int unsigned PAYLOAD_W = 10;

	// Stream data widths, rounded up to whole bytes.
	localparam int unsigned IN_DATA_W  = 96;
	localparam int unsigned OUT_DATA_W = 64;

	// Configuration port.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam logic [CFG_INDEX_W-1:0] REG_SERVER_ADDRESS   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BROADCAST_SEARCH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_QUIET_ERRORS     = 2'd2;

	// Command carried with each input transaction.
	localparam logic MODE_START  = 1'b0;
	localparam logic MODE_PACKET = 1'b1;

	// TFTP header.
	localparam logic [LEN_W-1:0]    HDR_BYTES = 11'd4;
	localparam logic [OPCODE_W-1:0] OP_DATA   = 16'd3;
	localparam logic [OPCODE_W-1:0] OP_ERROR  = 16'd5;

	// Verdict codes.
	localparam logic [VERDICT_W-1:0] V_SHORT      = 4'd0;
	localparam logic [VERDICT_W-1:0] V_PORT       = 4'd1;
	localparam logic [VERDICT_W-1:0] V_SERVER     = 4'd2;
	localparam logic [VERDICT_W-1:0] V_OPCODE     = 4'd3;
	localparam logic [VERDICT_W-1:0] V_SEARCH_ERR = 4'd4;
	localparam logic [VERDICT_W-1:0] V_ABORT      = 4'd5;
	localparam logic [VERDICT_W-1:0] V_SEQ        = 4'd6;
	localparam logic [VERDICT_W-1:0] V_OK         = 4'd7;
	localparam logic [VERDICT_W-1:0] V_OVERSIZE   = 4'd8;
	localparam logic [VERDICT_W-1:0] V_START      = 4'd9;

endpackage

// ----- hdl/tftp_data_receive_checker_core.sv -----
// ----------------------------------------------------------------------------
// TFTP data receive checker core
// Checks each received packet header of a TFTP read transfer, tracks the
// connection and block sequence, and decides whether to acknowledge.
// ----------------------------------------------------------------------------
// A result passes the input register and then the result register; a stall
// can hold it in either. Throughput: one transaction per cycle while the
// result side does not stall; the connection state is updated in the same
// cycle that a result is registered, so the next item sees it at once. A
// stalled result holds the input register, and the input side waits with it.
// Reset: arst_n clears the connection state, the configuration registers and
// both stage valid flags asynchronously; no clearing pass is needed.
module tftp_data_receive_checker_core #(
	parameter int unsigned SEGMENT_BYTES = tdrc_pkg::SEGMENT_BYTES_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,

	// Configuration write channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tdrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [tdrc_pkg::CFG_DATA_W-1:0]     cfg_data,

	// Input stream.
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata, lowest bit first: packet_length[10:0], source_port[26:11],
	// source_address[58:27], opcode[74:59], block_number[90:75], zeros above.
	input  logic [tdrc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// tuser: mode (0 start a new connection, 1 received packet header).
	input  logic                                s_axis_tuser,

	// Result stream.
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// tdata, lowest bit first: payload_bytes[9:0], send_ack[10],
	// ack_block[26:11], last_block[27], report_error[28],
	// current_server[60:29], zeros above.
	output logic [tdrc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// tuser: verdict[3:0].
	output logic [tdrc_pkg::VERDICT_W-1:0]      m_axis_tuser
);

	// Segment size and its trimmed form widened past the largest payload length
	// so that all compares are free of overflow.
	localparam int unsigned CMP_W = tdrc_pkg::LEN_W + 1;
	localparam logic [CMP_W-1:0] SEG_LEN      = CMP_W'(SEGMENT_BYTES);
	localparam logic [CMP_W-1:0] SEG_LEN_TRIM = CMP_W'(SEGMENT_BYTES + 2);

	// ------------------------------------------------------------------
	// Configuration registers. Writes are always taken; the user must write
	// only while the block is idle, which the block itself does not enforce.
	// ------------------------------------------------------------------
	logic [tdrc_pkg::ADDR_W-1:0] server_address_q;
	logic                        broadcast_search_q;
	logic                        quiet_errors_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_address_q   <= '0;
			broadcast_search_q <= 1'b0;
			quiet_errors_q     <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tdrc_pkg::REG_SERVER_ADDRESS:   server_address_q   <= cfg_data;
				tdrc_pkg::REG_BROADCAST_SEARCH: broadcast_search_q <= cfg_data[0];
				tdrc_pkg::REG_QUIET_ERRORS:     quiet_errors_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: input register. It moves on whenever the result register is
	// free or being emptied, so the input side never waits on an idle slot.
	// ------------------------------------------------------------------
	logic                              valid_s1;
	logic                              mode_s1;
	logic [tdrc_pkg::LEN_W-1:0]        len_s1;
	logic [tdrc_pkg::PORT_W-1:0]       sport_s1;
	logic [tdrc_pkg::ADDR_W-1:0]       saddr_s1;
	logic [tdrc_pkg::OPCODE_W-1:0]     op_s1;
	logic [tdrc_pkg::BLOCK_W-1:0]      blk_s1;

	logic valid_s2;
	logic advance;

	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			mode_s1  <= s_axis_tuser;
			len_s1   <= s_axis_tdata[10:0];
			sport_s1 <= s_axis_tdata[26:11];
			saddr_s1 <= s_axis_tdata[58:27];
			op_s1    <= s_axis_tdata[74:59];
			blk_s1   <= s_axis_tdata[90:75];
		end
	end

	// ------------------------------------------------------------------
	// Connection state.
	// ------------------------------------------------------------------
	logic                          connected_q;
	logic [tdrc_pkg::BLOCK_W-1:0]  blocks_received_q;
	logic [tdrc_pkg::PORT_W-1:0]   server_port_q;
	logic                          end_seen_q;
	logic                          searching_q;
	logic                          errors_quiet_q;
	logic [tdrc_pkg::ADDR_W-1:0]   server_in_use_q;

	logic                          connected_d;
	logic [tdrc_pkg::BLOCK_W-1:0]  blocks_received_d;
	logic [tdrc_pkg::PORT_W-1:0]   server_port_d;
	logic                          end_seen_d;
	logic                          searching_d;
	logic                          errors_quiet_d;
	logic [tdrc_pkg::ADDR_W-1:0]   server_in_use_d;

	logic [tdrc_pkg::VERDICT_W-1:0] verdict_d;
	logic [tdrc_pkg::PAYLOAD_W-1:0] payload_d;
	logic                           ack_d;
	logic [tdrc_pkg::BLOCK_W-1:0]   ack_blk_d;
	logic                           report_d;

	// Helper values. The header length is only used once it is known not to
	// be short, so the subtraction never wraps where it matters.
	logic                          foreign_src;
	logic [CMP_W-1:0]              data_len;
	logic [CMP_W-1:0]              trimmed_len;
	logic [tdrc_pkg::BLOCK_W-1:0]  next_blk;

	assign foreign_src = (saddr_s1 != server_in_use_q);
	assign data_len    = CMP_W'(len_s1) - CMP_W'(tdrc_pkg::HDR_BYTES);
	assign trimmed_len = (data_len == SEG_LEN_TRIM) ? SEG_LEN : data_len;

	always_comb begin
		connected_d       = connected_q;
		blocks_received_d = blocks_received_q;
		server_port_d     = server_port_q;
		end_seen_d        = end_seen_q;
		searching_d       = searching_q;
		errors_quiet_d    = errors_quiet_q;
		server_in_use_d   = server_in_use_q;
		verdict_d         = tdrc_pkg::V_SHORT;
		payload_d         = '0;
		ack_d             = 1'b0;
		ack_blk_d         = '0;
		report_d          = 1'b0;
		next_blk          = blocks_received_q + 1'b1;

		if (mode_s1 == tdrc_pkg::MODE_START) begin
			// A start drops any connection and loads the configured server.
			connected_d       = 1'b0;
			blocks_received_d = '0;
			server_port_d     = '0;
			end_seen_d        = 1'b0;
			searching_d       = broadcast_search_q;
			errors_quiet_d    = quiet_errors_q;
			server_in_use_d   = server_address_q;
			verdict_d         = tdrc_pkg::V_START;
		end else if (len_s1 < tdrc_pkg::HDR_BYTES) begin
			verdict_d = tdrc_pkg::V_SHORT;
		end else if (connected_q && (blocks_received_q != '0)
				&& (sport_s1 != server_port_q)) begin
			verdict_d = tdrc_pkg::V_PORT;
		end else if (foreign_src && !(searching_q && (op_s1 == tdrc_pkg::OP_DATA))) begin
			verdict_d = tdrc_pkg::V_SERVER;
		end else begin
			// Reaching here from a foreign address means a DATA packet found
			// during a broadcast search: that sender becomes the server.
			if (foreign_src) begin
				server_in_use_d = saddr_s1;
				searching_d     = 1'b0;
				errors_quiet_d  = 1'b0;
			end
			if (op_s1 == tdrc_pkg::OP_ERROR) begin
				// Adoption only happens for DATA, so the old search flag holds.
				if (searching_q) begin
					verdict_d = tdrc_pkg::V_SEARCH_ERR;
				end else begin
					verdict_d = tdrc_pkg::V_ABORT;
					report_d  = !errors_quiet_q;
				end
			end else if (op_s1 != tdrc_pkg::OP_DATA) begin
				verdict_d = tdrc_pkg::V_OPCODE;
			end else begin
				errors_quiet_d = 1'b0;
				// The first DATA packet opens the connection and restarts the
				// count, so the sequence check below expects block one.
				if (!connected_q) begin
					server_port_d     = sport_s1;
					connected_d       = 1'b1;
					blocks_received_d = '0;
					end_seen_d        = 1'b0;
					next_blk          = {{(tdrc_pkg::BLOCK_W-1){1'b0}}, 1'b1};
				end
				if (blk_s1 != next_blk) begin
					verdict_d = tdrc_pkg::V_SEQ;
					// Repeat the last acknowledgement if there was one.
					if (blocks_received_d != '0) begin
						ack_d     = 1'b1;
						ack_blk_d = blocks_received_d;
					end
				end else begin
					blocks_received_d = next_blk;
					if (trimmed_len > SEG_LEN) begin
						verdict_d = tdrc_pkg::V_OVERSIZE;
					end else begin
						verdict_d = tdrc_pkg::V_OK;
						payload_d = trimmed_len[tdrc_pkg::PAYLOAD_W-1:0];
						if (trimmed_len < SEG_LEN) begin
							end_seen_d = 1'b1;
						end
						ack_d     = 1'b1;
						ack_blk_d = next_blk;
					end
				end
			end
		end
	end

	logic consume;
	assign consume = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			connected_q       <= 1'b0;
			blocks_received_q <= '0;
			server_port_q     <= '0;
			end_seen_q        <= 1'b0;
			searching_q       <= 1'b0;
			errors_quiet_q    <= 1'b0;
			server_in_use_q   <= '0;
		end else if (consume) begin
			connected_q       <= connected_d;
			blocks_received_q <= blocks_received_d;
			server_port_q     <= server_port_d;
			end_seen_q        <= end_seen_d;
			searching_q       <= searching_d;
			errors_quiet_q    <= errors_quiet_d;
			server_in_use_q   <= server_in_use_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: result register, held while the downstream side stalls.
	// ------------------------------------------------------------------
	logic [tdrc_pkg::VERDICT_W-1:0] verdict_s2;
	logic [tdrc_pkg::PAYLOAD_W-1:0] payload_s2;
	logic                           ack_s2;
	logic [tdrc_pkg::BLOCK_W-1:0]   ack_blk_s2;
	logic                           last_s2;
	logic                           report_s2;
	logic [tdrc_pkg::ADDR_W-1:0]    server_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			verdict_s2 <= verdict_d;
			payload_s2 <= payload_d;
			ack_s2     <= ack_d;
			ack_blk_s2 <= ack_blk_d;
			last_s2    <= end_seen_d;
			report_s2  <= report_d;
			server_s2  <= server_in_use_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = verdict_s2;
	assign m_axis_tdata  = {3'b000, server_s2, report_s2, last_s2, ack_blk_s2, ack_s2,
		payload_s2};

endmodule

// ----- test/tftp_data_receive_checker_core_tb.sv -----
// ----------------------------------------------------------------------------
// TFTP data receive checker core testbench
// Drives start commands and received packet headers into the checker. A
// transfer tracker predicts the verdict of every transaction and checks the
// result stream field by field. Register settings change between phases, and
// the two stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tftp_data_receive_checker_core_tb;

	localparam int unsigned SEG          = tdrc_pkg::SEGMENT_BYTES_DEFAULT;
	localparam int          LIMIT_CYCLES = 1_000_000;
	// Payload sizes at the width of a packet length.
	localparam logic [tdrc_pkg::LEN_W-1:0] SEG_N    = tdrc_pkg::LEN_W'(SEG);
	localparam logic [tdrc_pkg::LEN_W-1:0] SEG_TRIM = tdrc_pkg::LEN_W'(SEG + 2);
	// Index 3 is not a register; a write there must leave the settings alone.
	localparam logic [tdrc_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	// One expected result, held with the fields at the block's widths.
	typedef struct packed {
		logic [tdrc_pkg::VERDICT_W-1:0] verdict;
		logic [tdrc_pkg::PAYLOAD_W-1:0] payload;
		logic                           ack;
		logic [tdrc_pkg::BLOCK_W-1:0]   ack_block;
		logic                           last;
		logic                           report;
		logic [tdrc_pkg::ADDR_W-1:0]    server;
	} verdict_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [tdrc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [tdrc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [tdrc_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
	logic                             s_axis_tuser = 1'b0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [tdrc_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
	logic [tdrc_pkg::VERDICT_W-1:0]   m_axis_tuser;

	tftp_data_receive_checker_core #(
		.SEGMENT_BYTES(SEG)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// ------------------------------------------------------------------------
	// Transfer tracker: its own copy of the registers and connection state,
	// a verdict predictor and the queue of results still to arrive.
	// ------------------------------------------------------------------------
	class transfer_tracker_t;
		bit [tdrc_pkg::ADDR_W-1:0]  reg_server;
		bit                         reg_search;
		bit                         reg_quiet;
		bit                         connected;
		bit [tdrc_pkg::BLOCK_W-1:0] blocks;
		bit [tdrc_pkg::PORT_W-1:0]  port_latched;
		bit                         end_seen;
		bit                         searching;
		bit                         quiet;
		bit [tdrc_pkg::ADDR_W-1:0]  server;
		verdict_t                   awaited[$];
		int                         faults;
		int                         results;
		bit [9:0]                   verdicts_seen;

		function void write_reg(input logic [tdrc_pkg::CFG_INDEX_W-1:0] idx,
				input logic [tdrc_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				tdrc_pkg::REG_SERVER_ADDRESS:   reg_server = data;
				tdrc_pkg::REG_BROADCAST_SEARCH: reg_search = data[0];
				tdrc_pkg::REG_QUIET_ERRORS:     reg_quiet  = data[0];
				default: ;
			endcase
		endfunction

		// Works out the result of one accepted input transaction and queues it.
		function void note_packet(input logic mode,
				input logic [tdrc_pkg::LEN_W-1:0] len,
				input logic [tdrc_pkg::PORT_W-1:0] port,
				input logic [tdrc_pkg::ADDR_W-1:0] addr,
				input logic [tdrc_pkg::OPCODE_W-1:0] op,
				input logic [tdrc_pkg::BLOCK_W-1:0] blk);
			verdict_t                   want;
			bit [tdrc_pkg::BLOCK_W-1:0] next_blk;
			bit [tdrc_pkg::LEN_W-1:0]   n;
			want = '0;
			next_blk = blocks + 16'd1;
			if (mode == tdrc_pkg::MODE_START) begin
				connected    = 1'b0;
				blocks       = '0;
				port_latched = '0;
				end_seen     = 1'b0;
				searching    = reg_search;
				quiet        = reg_quiet;
				server       = reg_server;
				want.verdict = tdrc_pkg::V_START;
			end else if (len < tdrc_pkg::HDR_BYTES) begin
				want.verdict = tdrc_pkg::V_SHORT;
			end else if (connected && blocks != '0 && port != port_latched) begin
				want.verdict = tdrc_pkg::V_PORT;
			end else if (addr != server && !(searching && op == tdrc_pkg::OP_DATA)) begin
				want.verdict = tdrc_pkg::V_SERVER;
			end else begin
				// A DATA packet from a new address during the search adopts it.
				if (addr != server) begin
					server    = addr;
					searching = 1'b0;
					quiet     = 1'b0;
				end
				if (op == tdrc_pkg::OP_ERROR) begin
					if (searching) begin
						want.verdict = tdrc_pkg::V_SEARCH_ERR;
					end else begin
						want.verdict = tdrc_pkg::V_ABORT;
						want.report  = !quiet;
					end
				end else if (op != tdrc_pkg::OP_DATA) begin
					want.verdict = tdrc_pkg::V_OPCODE;
				end else begin
					quiet = 1'b0;
					// The first DATA block fixes the server port.
					if (!connected) begin
						port_latched = port;
						connected    = 1'b1;
						blocks       = '0;
						end_seen     = 1'b0;
						next_blk     = 16'd1;
					end
					if (blk != next_blk) begin
						want.verdict = tdrc_pkg::V_SEQ;
						// Repeat the last acknowledgement, if there was one.
						if (blocks != '0) begin
							want.ack       = 1'b1;
							want.ack_block = blocks;
						end
					end else begin
						blocks = next_blk;
						n = len - tdrc_pkg::HDR_BYTES;
						// A payload two bytes over the segment is cut back to it.
						if (n == SEG_TRIM)
							n = SEG_N;
						if (n > SEG_N) begin
							want.verdict = tdrc_pkg::V_OVERSIZE;
						end else begin
							want.verdict   = tdrc_pkg::V_OK;
							want.payload   = n[tdrc_pkg::PAYLOAD_W-1:0];
							want.ack       = 1'b1;
							want.ack_block = blocks;
							if (n < SEG_N)
								end_seen = 1'b1;
						end
					end
				end
			end
			want.last   = end_seen;
			want.server = server;
			awaited.push_back(want);
		endfunction

		function void compare(input string field, input logic [31:0] want,
				input logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, field,
					want, got);
				faults++;
			end
		endfunction

		// Checks one accepted result transaction against the oldest expectation.
		function void check_result(input logic [tdrc_pkg::OUT_DATA_W-1:0] data,
				input logic [tdrc_pkg::VERDICT_W-1:0] user);
			verdict_t want;
			if (awaited.size() == 0) begin
				$display("%0t: result with no expectation, verdict %0h data %0h",
					$time, user, data);
				faults++;
				return;
			end
			want = awaited.pop_front();
			results++;
			verdicts_seen[want.verdict] = 1'b1;
			compare("verdict", 32'(want.verdict), 32'(user));
			compare("payload_bytes", 32'(want.payload), 32'(data[9:0]));
			compare("send_ack", 32'(want.ack), 32'(data[10]));
			compare("ack_block", 32'(want.ack_block), 32'(data[26:11]));
			compare("last_block", 32'(want.last), 32'(data[27]));
			compare("report_error", 32'(want.report), 32'(data[28]));
			compare("current_server", want.server, data[60:29]);
		endfunction
	endclass

	transfer_tracker_t tracker = new();

	int cycles = 0;
	int items_sent = 0;
	int settings = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int stall_left = 0;
	int gap_mix[6] = '{15, 0, 40, 15, 25, 0};
	int stall_mix[6] = '{15, 30, 0, 40, 15, 0};

	always #5 clk = ~clk;

	// Result side: the receiver stalls in random bursts.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			if (stall_left == 1)
				m_axis_tready <= 1'b1;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			m_axis_tready <= 1'b0;
			stall_left <= $urandom_range(1, 15);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Every result transaction is checked at the edge that takes it.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_result(m_axis_tdata, m_axis_tuser);
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("[tftp_data_receive_checker_core] ERROR");
			$finish;
		end
	end

	// Offers one input transaction, possibly after a random gap, and hands it to
	// the tracker at the edge where it is taken. tvalid is left high so that a
	// following transaction can go back to back.
	task automatic send_item(input logic mode, input logic [tdrc_pkg::LEN_W-1:0] len,
			input logic [tdrc_pkg::PORT_W-1:0] port,
			input logic [tdrc_pkg::ADDR_W-1:0] addr,
			input logic [tdrc_pkg::OPCODE_W-1:0] op,
			input logic [tdrc_pkg::BLOCK_W-1:0] blk);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {5'b0, blk, op, addr, port, len};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		tracker.note_packet(mode, len, port, addr, op, blk);
		items_sent++;
	endtask

	task automatic packet(input logic [tdrc_pkg::LEN_W-1:0] len,
			input logic [tdrc_pkg::PORT_W-1:0] port,
			input logic [tdrc_pkg::ADDR_W-1:0] addr,
			input logic [tdrc_pkg::OPCODE_W-1:0] op,
			input logic [tdrc_pkg::BLOCK_W-1:0] blk);
		send_item(tdrc_pkg::MODE_PACKET, len, port, addr, op, blk);
	endtask

	// A start command; the header fields carry noise that must be ignored.
	task automatic start_transfer();
		send_item(tdrc_pkg::MODE_START, 11'($urandom), 16'($urandom), $urandom,
			16'($urandom), 16'($urandom));
	endtask

	task automatic write_register(input logic [tdrc_pkg::CFG_INDEX_W-1:0] idx,
			input logic [tdrc_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.write_reg(idx, data);
	endtask

	// Waits until the checker is idle, then loads a new set of registers. The
	// single-bit registers sometimes carry junk in their upper bits.
	task automatic reprogram(input logic [tdrc_pkg::ADDR_W-1:0] addr, input bit search,
			input bit quiet, input bit spare);
		logic [tdrc_pkg::CFG_DATA_W-1:0] junk;
		s_axis_tvalid <= 1'b0;
		while (tracker.awaited.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		junk = $urandom_range(0, 1) ? ($urandom & ~32'd1) : '0;
		write_register(tdrc_pkg::REG_SERVER_ADDRESS, addr);
		write_register(tdrc_pkg::REG_BROADCAST_SEARCH,
			{junk[tdrc_pkg::CFG_DATA_W-1:1], search});
		write_register(tdrc_pkg::REG_QUIET_ERRORS,
			{junk[tdrc_pkg::CFG_DATA_W-1:1], quiet});
		if (spare)
			write_register(REG_SPARE, $urandom);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// Mostly the next block of the transfer in progress, with random sizes, and
	// around it duplicates, foreign ports and senders, error packets, unknown
	// opcodes, short packets and fresh starts.
	task automatic random_packet();
		int                             r;
		logic                           mode;
		logic [tdrc_pkg::LEN_W-1:0]     len;
		logic [tdrc_pkg::PORT_W-1:0]    port;
		logic [tdrc_pkg::ADDR_W-1:0]    addr;
		logic [tdrc_pkg::OPCODE_W-1:0]  op;
		logic [tdrc_pkg::BLOCK_W-1:0]   blk;
		mode = tdrc_pkg::MODE_PACKET;
		len  = 11'd516;
		port = tracker.connected ? tracker.port_latched : 16'($urandom);
		addr = tracker.server;
		op   = tdrc_pkg::OP_DATA;
		blk  = tracker.blocks + 16'd1;
		if (tracker.searching && $urandom_range(0, 1))
			addr = $urandom;
		r = $urandom_range(0, 99);
		if (r < 4 || (tracker.end_seen && r < 30)) begin
			mode = tdrc_pkg::MODE_START;
			len  = 11'($urandom);
			port = 16'($urandom);
			addr = $urandom;
			op   = 16'($urandom);
			blk  = 16'($urandom);
		end else if (r < 62) begin
			case ($urandom_range(0, 9))
				5:       len = 11'd518;
				6, 7:    len = 11'($urandom_range(4, 515));
				8:       len = 11'd517;
				9:       len = 11'($urandom_range(519, 2047));
				default: len = 11'd516;
			endcase
		end else if (r < 70) begin
			blk = $urandom_range(0, 1) ? tracker.blocks : 16'($urandom);
		end else if (r < 76) begin
			port = port ^ 16'($urandom_range(1, 65535));
		end else if (r < 82) begin
			addr = $urandom;
			op   = $urandom_range(0, 1) ? tdrc_pkg::OP_ERROR : tdrc_pkg::OP_DATA;
		end else if (r < 88) begin
			op = tdrc_pkg::OP_ERROR;
		end else if (r < 92) begin
			op = 16'($urandom);
		end else begin
			len  = $urandom_range(0, 1) ? 11'($urandom_range(0, 3)) : 11'($urandom);
			port = 16'($urandom);
			addr = $urandom_range(0, 1) ? addr : $urandom;
			op   = $urandom_range(0, 1) ? tdrc_pkg::OP_DATA : 16'($urandom);
			blk  = 16'($urandom);
		end
		send_item(mode, len, port, addr, op, blk);
	endtask

	initial begin
		logic [tdrc_pkg::ADDR_W-1:0] srv;
		logic [tdrc_pkg::ADDR_W-1:0] foreign;
		logic [tdrc_pkg::PORT_W-1:0] sport;
		srv     = 32'h0A00_0001;
		foreign = 32'hC0A8_0107;
		sport   = 16'h8001;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight out of reset the server address is zero and nothing is
		// connected, so a first block from address zero is taken.
		packet(11'd10, 16'h1234, 32'h0, tdrc_pkg::OP_DATA, 16'd1);

		// Plain transfer from a known server: every rejection path, the trim of
		// a two-byte overrun, oversize blocks and the end of file.
		reprogram(srv, 1'b0, 1'b0, 1'b0);
		start_transfer();
		packet(11'd0, sport, srv, tdrc_pkg::OP_DATA, 16'd1);
		packet(11'd3, sport, srv, tdrc_pkg::OP_DATA, 16'd1);
		packet(11'd516, sport, foreign, tdrc_pkg::OP_DATA, 16'd1);
		packet(11'd20, sport, srv, tdrc_pkg::OP_ERROR, 16'd0);
		packet(11'd4, sport, srv, 16'd0, 16'd1);
		packet(11'd4, sport, srv, 16'hFFFF, 16'd1);
		packet(11'd516, sport, srv, tdrc_pkg::OP_DATA, 16'd2);
		packet(11'd516, sport, srv, tdrc_pkg::OP_DATA, 16'd1);
		packet(11'd516, ~sport, srv, tdrc_pkg::OP_DATA, 16'd2);
		packet(11'd518, sport, srv, tdrc_pkg::OP_DATA, 16'd2);
		packet(11'd517, sport, srv, tdrc_pkg::OP_DATA, 16'd3);
		packet(11'd516, sport, srv, tdrc_pkg::OP_DATA, 16'd3);
		packet(11'd2047, sport, srv, tdrc_pkg::OP_DATA, 16'd4);
		packet(11'd4, sport, srv, tdrc_pkg::OP_DATA, 16'd5);

		// Broadcast search with quiet errors: errors are refused or ignored until
		// the first DATA sender is adopted, which also ends the quiet period.
		reprogram(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
		start_transfer();
		packet(11'd20, 16'd69, foreign, tdrc_pkg::OP_ERROR, 16'd0);
		packet(11'd20, 16'd69, 32'hFFFF_FFFF, tdrc_pkg::OP_ERROR, 16'd0);
		packet(11'd4, 16'd69, foreign, 16'd4, 16'd1);
		packet(11'd300, 16'd0, foreign, tdrc_pkg::OP_DATA, 16'd1);
		packet(11'd20, 16'd0, foreign, tdrc_pkg::OP_ERROR, 16'd0);

		// Quiet errors without a search: the first server error goes unreported.
		reprogram(32'h0, 1'b0, 1'b1, 1'b0);
		start_transfer();
		packet(11'd20, 16'hFFFF, 32'h0, tdrc_pkg::OP_ERROR, 16'd0);
		packet(11'd516, 16'hFFFF, 32'h0, tdrc_pkg::OP_DATA, 16'd1);
		packet(11'd20, 16'hFFFF, 32'h0, tdrc_pkg::OP_ERROR, 16'd0);

		// Random transfers under changing settings and idling patterns; the
		// final phase runs with neither side idling.
		for (int ph = 0; ph < 6; ph++) begin
			reprogram(ph == 0 ? 32'h0 : ph == 1 ? 32'hFFFF_FFFF : $urandom,
				ph[0], ph[1], ph == 2);
			gap_pct   = gap_mix[ph];
			stall_pct = stall_mix[ph];
			start_transfer();
			repeat (100) random_packet();
		end

		s_axis_tvalid <= 1'b0;
		while (tracker.awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d start and header transactions under %0d register settings;",
			items_sent, settings);
		$display("%0d results checked, %0d of 10 verdicts seen.",
			tracker.results, $countones(tracker.verdicts_seen));
		if (tracker.faults == 0 && tracker.awaited.size() == 0) begin
			$display("[tftp_data_receive_checker_core] OK");
		end else begin
			$display("[tftp_data_receive_checker_core] ERROR");
		end
		$finish;
	end

endmodule

// ----- tftp_data_receive_checker_core.f -----
hdl/tdrc_pkg.sv
hdl/tftp_data_receive_checker_core.sv
test/tftp_data_receive_checker_core_tb.sv
